// ===== rtl/core/page_framebuffer_flush_engine_top_defines.svh =====
// Assertion macros for the checker file of the frame store block.
// Depends on nothing; the using module must have clk and rst_n in scope.
`ifndef PAGE_FRAMEBUFFER_FLUSH_ENGINE_TOP_DEFINES_SVH
`define PAGE_FRAMEBUFFER_FLUSH_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PFFE_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pffe same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PFFE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pffe next-cycle check failed");

`endif

// ===== rtl/core/pffe_pkg.sv =====
// Package for the page frame store flush engine: sizes, payload beat types.
// Depends on nothing; used by the top level and the port checker.
`timescale 1ns / 1ps

package pffe_pkg;

    localparam int PANEL_COLUMNS   = 128;
    localparam int PAGE_COUNT      = 8;
    localparam int MAX_DATA_WORDS  = 16;
    localparam int MAX_DATA_BYTES  = 8 * MAX_DATA_WORDS;
    localparam int STORE_BYTES     = PANEL_COLUMNS * PAGE_COUNT;
    localparam int ADDR_W          = $clog2(STORE_BYTES);
    localparam int N_W             = $clog2(MAX_DATA_BYTES + 1);
    localparam int CALC_W          = 10;

    localparam logic [7:0] PAGE_ADDR_BASE = 8'hB0;
    localparam logic [7:0] COL_HIGH_BASE  = 8'h10;
    localparam logic [7:0] FILL_LIT       = 8'hFF;
    localparam logic [7:0] FILL_DARK      = 8'h00;

    localparam logic [1:0] ACT_PIXEL = 2'd0;
    localparam logic [1:0] ACT_FLUSH = 2'd1;
    localparam logic [1:0] ACT_FILL  = 2'd2;

    localparam logic [1:0] REG_PANEL_ROWS   = 2'd0;
    localparam logic [1:0] REG_PAGE_SHIFT   = 2'd1;
    localparam logic [1:0] REG_COLUMN_SHIFT = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] column;
        logic [5:0] row;
        logic [7:0] col_count;
        logic       color;
    } in_item_t;

    typedef struct packed {
        logic        is_command;
        logic [3:0]  byte_count;
        logic [63:0] word_bytes;
        logic        last;
    } out_item_t;

endpackage

// ===== rtl/core/pffe_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module pffe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ===== rtl/core/page_framebuffer_flush_engine_top.sv =====
// Top level of the page frame store and flush engine.
// Depends on pffe_pkg and the generic RAM pffe_ram.
//
// Usage: input beats on in_valid/in_ready/in_data write one pixel, fill the
// whole store, or flush part of one page. Result beats leave on
// out_valid/out_ready/out_data; register writes come on cfg_valid/cfg_data.
// A pixel write is a read-modify-write of one store byte.
// A fill writes one byte per cycle across all 1024 store bytes.
// A flush enters its command state on acceptance, loads its command beat,
// then reads each data beat of up to eight bytes from the store in turn,
// since every byte passes through the single port of the byte-wide store.
// One item is worked on at a time; in_ready is high only while idle.
// After reset all 1024 store bytes are cleared with in_ready low;
// register writes are taken at any time and the registers reset to 64, 0, 0.
// When the receiver stalls, the result beat holds in the output register
// and the flush gathers its next beat but waits to load it.
`timescale 1ns / 1ps

module page_framebuffer_flush_engine_top
    import pffe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_PIX_WR,
        ST_CMD,
        ST_DATA
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [7:0]        fill_val_reg;
    logic [7:0]        pix_bit_reg;
    logic              color_reg;
    logic [N_W-1:0]    remain_reg;
    logic [3:0]        wlen_reg;
    logic [3:0]        issued_reg;
    logic [3:0]        cap_reg;
    logic              pend_reg;
    logic [63:0]       word_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;
    logic [6:0]        panel_rows_reg;
    logic [2:0]        page_shift_reg;
    logic [3:0]        column_shift_reg;

    logic              ram_en;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    logic              in_fire;
    logic              out_free;
    logic              out_load;
    logic [2:0]        in_page;
    logic              pix_ok;
    logic [ADDR_W-1:0] pix_addr;
    logic [CALC_W-1:0] avail;
    logic [CALC_W-1:0] n_calc;
    logic [N_W-1:0]    flush_n;
    logic [7:0]        start_col;
    logic [63:0]       cmd_word;
    logic              rd_issue;
    logic [3:0]        first_wlen;

    pffe_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = out_free
                    && ((state_reg == ST_CMD)
                        || ((state_reg == ST_DATA) && !pend_reg && (cap_reg == wlen_reg)));

    assign in_page  = in_data.row[5:3];
    assign pix_ok   = (CALC_W'(in_data.column) < CALC_W'(PANEL_COLUMNS))
                   && (7'(in_data.row) < panel_rows_reg)
                   && (CALC_W'(in_data.row) < CALC_W'(8 * PAGE_COUNT));
    assign pix_addr = ADDR_W'(in_page) * ADDR_W'(PANEL_COLUMNS)
                    + ADDR_W'(in_data.column);

    assign start_col = 8'(in_data.column) + 8'(column_shift_reg);
    assign cmd_word  = {40'd0,
                        4'd0, start_col[3:0],
                        8'(COL_HIGH_BASE + 8'(start_col[7:4])),
                        8'(PAGE_ADDR_BASE + 8'(in_page) + 8'(page_shift_reg))};

    always_comb
    begin
        avail  = CALC_W'(PANEL_COLUMNS) - CALC_W'(in_data.column);
        n_calc = CALC_W'(in_data.col_count);
        if (avail < n_calc)
        begin
            n_calc = avail;
        end
        if (CALC_W'(MAX_DATA_BYTES) < n_calc)
        begin
            n_calc = CALC_W'(MAX_DATA_BYTES);
        end
        if ((CALC_W'(in_page) >= CALC_W'(PAGE_COUNT))
            || (CALC_W'(in_data.column) >= CALC_W'(PANEL_COLUMNS)))
        begin
            n_calc = '0;
        end
        flush_n = N_W'(n_calc);
    end

    assign first_wlen = (remain_reg > N_W'(8)) ? 4'd8 : 4'(remain_reg);
    assign rd_issue   = (state_reg == ST_DATA) && (issued_reg != wlen_reg);

    always_comb
    begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = addr_reg;
        ram_wdata = fill_val_reg;
        case (state_reg)
            ST_FILL:
            begin
                ram_en = 1'b1;
                ram_we = 1'b1;
            end
            ST_IDLE:
            begin
                if (in_fire && in_data.action == ACT_PIXEL && pix_ok)
                begin
                    ram_en   = 1'b1;
                    ram_addr = pix_addr;
                end
            end
            ST_PIX_WR:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = color_reg ? (ram_rdata | pix_bit_reg)
                                      : (ram_rdata & ~pix_bit_reg);
            end
            ST_DATA:
            begin
                ram_en = rd_issue;
            end
            default:
            begin
                ram_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_FILL;
            addr_reg         <= '0;
            fill_val_reg     <= FILL_DARK;
            pend_reg         <= 1'b0;
            issued_reg       <= '0;
            cap_reg          <= '0;
            wlen_reg         <= '0;
            remain_reg       <= '0;
            out_valid_reg    <= 1'b0;
            panel_rows_reg   <= 7'd64;
            page_shift_reg   <= '0;
            column_shift_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PANEL_ROWS:   panel_rows_reg   <= cfg_data;
                    REG_PAGE_SHIFT:   page_shift_reg   <= cfg_data[2:0];
                    REG_COLUMN_SHIFT: column_shift_reg <= cfg_data[3:0];
                    default:          panel_rows_reg   <= panel_rows_reg;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            pend_reg <= rd_issue;

            case (state_reg)
                ST_FILL:
                begin
                    if (addr_reg == ADDR_W'(STORE_BYTES - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + ADDR_W'(1);
                    end
                end
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        case (in_data.action)
                            ACT_PIXEL:
                            begin
                                if (pix_ok)
                                begin
                                    addr_reg    <= pix_addr;
                                    pix_bit_reg <= 8'(1) << in_data.row[2:0];
                                    color_reg   <= in_data.color;
                                    state_reg   <= ST_PIX_WR;
                                end
                            end
                            ACT_FLUSH:
                            begin
                                addr_reg   <= pix_addr;
                                remain_reg <= flush_n;
                                word_reg   <= cmd_word;
                                state_reg  <= ST_CMD;
                            end
                            ACT_FILL:
                            begin
                                addr_reg     <= '0;
                                fill_val_reg <= in_data.color ? FILL_LIT : FILL_DARK;
                                state_reg    <= ST_FILL;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_PIX_WR:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_CMD:
                begin
                    if (out_free)
                    begin
                        out_data_reg.is_command   <= 1'b1;
                        out_data_reg.byte_count   <= 4'd3;
                        out_data_reg.word_bytes   <= word_reg;
                        out_data_reg.last         <= (remain_reg == '0);
                        word_reg                  <= '0;
                        wlen_reg                  <= first_wlen;
                        issued_reg                <= '0;
                        cap_reg                   <= '0;
                        state_reg <= (remain_reg == '0) ? ST_IDLE : ST_DATA;
                    end
                end
                ST_DATA:
                begin
                    if (rd_issue)
                    begin
                        addr_reg   <= addr_reg + ADDR_W'(1);
                        issued_reg <= issued_reg + 4'd1;
                    end
                    if (pend_reg)
                    begin
                        word_reg[cap_reg[2:0] * 8 +: 8] <= ram_rdata;
                        cap_reg <= cap_reg + 4'd1;
                    end
                    if (!pend_reg && cap_reg == wlen_reg && out_free)
                    begin
                        out_data_reg.is_command <= 1'b0;
                        out_data_reg.byte_count <= wlen_reg;
                        out_data_reg.word_bytes <= word_reg;
                        out_data_reg.last       <= (remain_reg == N_W'(wlen_reg));
                        remain_reg              <= remain_reg - N_W'(wlen_reg);
                        word_reg                <= '0;
                        issued_reg              <= '0;
                        cap_reg                 <= '0;
                        wlen_reg <= ((remain_reg - N_W'(wlen_reg)) > N_W'(8))
                                    ? 4'd8 : 4'(remain_reg - N_W'(wlen_reg));
                        if (remain_reg == N_W'(wlen_reg))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/pffe_checker.sv =====
// Port-level checks on the page frame store flush engine, bound to its top.
// Depends on pffe_pkg and page_framebuffer_flush_engine_top_defines.svh.
`timescale 1ns / 1ps
`include "page_framebuffer_flush_engine_top_defines.svh"

module pffe_checker
    import pffe_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    `PFFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    `PFFE_ASSERT_IMP(a_count_range, out_valid, out_data.byte_count != 4'd0 && out_data.byte_count <= 4'd8)
    `PFFE_ASSERT_IMP(a_cmd_word, out_valid && out_data.is_command, out_data.byte_count == 4'd3 && out_data.word_bytes[63:24] == 40'd0)
    `PFFE_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid)

endmodule

bind page_framebuffer_flush_engine_top pffe_checker u_pffe_checker (.*);

// ===== bench/tb_page_framebuffer_flush_engine_top.sv =====
// Self-checking bench for the page frame store flush engine: directed and random
// pixel, fill and flush beats under several register settings, checked against a
// shadow frame store. Depends on pffe_pkg and page_framebuffer_flush_engine_top.
`timescale 1ns / 1ps

module tb_page_framebuffer_flush_engine_top;
    import pffe_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 1100;
    localparam int CYCLE_LIMIT   = 400000;

    class frame_shadow;
        bit [7:0]    shadow_store [STORE_BYTES];
        int unsigned visible_rows = 64;
        bit [2:0]    page_adjust = 3'd0;
        bit [3:0]    column_adjust = 4'd0;
        out_item_t   beats_due [$];
        int          mismatches = 0;

        task report(string what);
            mismatches++;
            if (mismatches <= 40)
                $display("mismatch at %0t: %s", $realtime, what);
        endtask

        function void write_register(logic [1:0] index, logic [6:0] value);
            case (index)
                REG_PANEL_ROWS:   visible_rows = value;
                REG_PAGE_SHIFT:   page_adjust = value[2:0];
                REG_COLUMN_SHIFT: column_adjust = value[3:0];
                default: ;
            endcase
        endfunction

        function void accept_item(in_item_t item);
            int unsigned page;
            int unsigned start;
            int unsigned n;
            int unsigned len;
            int unsigned base;
            int unsigned pos;
            logic [7:0]  b0;
            logic [7:0]  b1;
            logic [7:0]  b2;
            out_item_t   beat;
            case (item.action)
                ACT_PIXEL:
                begin
                    if (item.row < visible_rows)
                    begin
                        pos = item.column + (item.row >> 3) * PANEL_COLUMNS;
                        shadow_store[pos][item.row[2:0]] = item.color;
                    end
                end
                ACT_FILL:
                begin
                    foreach (shadow_store[i])
                        shadow_store[i] = item.color ? FILL_LIT : FILL_DARK;
                end
                ACT_FLUSH:
                begin
                    page  = item.row >> 3;
                    start = item.column + column_adjust;
                    n     = item.col_count;
                    if (n > PANEL_COLUMNS - item.column)
                        n = PANEL_COLUMNS - item.column;
                    if (n > MAX_DATA_BYTES)
                        n = MAX_DATA_BYTES;
                    b0 = 8'(PAGE_ADDR_BASE + page + page_adjust);
                    b1 = 8'(COL_HIGH_BASE + (start >> 4));
                    b2 = 8'(start & 15);
                    beat.is_command = 1'b1;
                    beat.byte_count = 4'd3;
                    beat.word_bytes = {40'd0, b2, b1, b0};
                    beat.last       = (n == 0);
                    beats_due.push_back(beat);
                    base = page * PANEL_COLUMNS + item.column;
                    for (int unsigned i = 0; i < n; i += 8)
                    begin
                        len = (n - i < 8) ? n - i : 8;
                        beat.is_command = 1'b0;
                        beat.byte_count = 4'(len);
                        beat.word_bytes = 64'd0;
                        for (int unsigned b = 0; b < len; b++)
                            beat.word_bytes[8 * b +: 8] = shadow_store[base + i + b];
                        beat.last = (i + len >= n);
                        beats_due.push_back(beat);
                    end
                end
                default: ;
            endcase
        endfunction

        task check_beat(out_item_t got);
            out_item_t want;
            if (beats_due.size() == 0)
            begin
                report($sformatf("beat with nothing expected: %h", got));
            end
            else
            begin
                want = beats_due.pop_front();
                if (got.is_command !== want.is_command)
                    report($sformatf("is_command %b, expected %b", got.is_command,
                                     want.is_command));
                if (got.byte_count !== want.byte_count)
                    report($sformatf("byte_count %0d, expected %0d", got.byte_count,
                                     want.byte_count));
                if (got.word_bytes !== want.word_bytes)
                    report($sformatf("word_bytes %h, expected %h", got.word_bytes,
                                     want.word_bytes));
                if (got.last !== want.last)
                    report($sformatf("last %b, expected %b", got.last, want.last));
            end
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = REG_PANEL_ROWS;
    logic [6:0] cfg_data = 7'd0;

    int          idle_pct = 7;
    int          cycle_count = 0;
    frame_shadow shadow = new();

    page_framebuffer_flush_engine_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            shadow.check_beat(out_data);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic in_item_t make_item(logic [1:0] action, int column, int row,
                                           int count, logic color);
        in_item_t item;
        item.action    = action;
        item.column    = 7'(column);
        item.row       = 6'(row);
        item.col_count = 8'(count);
        item.color     = color;
        return item;
    endfunction

    function automatic in_item_t random_item();
        int       pick;
        int       count;
        int       column;
        in_item_t item;
        pick   = $urandom_range(99);
        column = ($urandom_range(3) == 0) ? 0 : $urandom_range(127);
        case ($urandom_range(19))
            0, 1:                 count = 0;
            2, 3, 4, 5, 6, 7, 8:  count = $urandom_range(1, 16);
            9, 10, 11, 12, 13, 14, 15: count = $urandom_range(1, 128);
            default:              count = $urandom_range(129, 255);
        endcase
        if (pick < 55)
            item = make_item(ACT_PIXEL, $urandom_range(127), $urandom_range(63), 0,
                             1'($urandom_range(1)));
        else if (pick < 88)
            item = make_item(ACT_FLUSH, column, $urandom_range(63), count, 1'b0);
        else if (pick < 92)
            item = make_item(ACT_FILL, 0, 0, 0, 1'($urandom_range(1)));
        else
            item = make_item(ACT_UNUSED, $urandom_range(127), $urandom_range(63),
                             $urandom_range(255), 1'($urandom_range(1)));
        if (item.action != ACT_UNUSED)
        begin
            item.column[6]    = item.column[6] | (item.action == ACT_PIXEL && pick[0]);
            item.col_count[0] = item.col_count[0] | (item.action == ACT_PIXEL && pick[1]);
        end
        return item;
    endfunction

    task automatic send_item(input in_item_t item);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < idle_pct)
                @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        shadow.accept_item(item);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [6:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow.write_register(index, value);
        @(negedge clk);
    endtask

    task automatic configure(input logic [6:0] rows, input logic [6:0] page_value,
                             input logic [6:0] column_value);
        write_reg(REG_PANEL_ROWS, rows);
        write_reg(REG_PAGE_SHIFT, page_value);
        write_reg(REG_COLUMN_SHIFT, column_value);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (shadow.beats_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_random(input int items);
        repeat (items) send_item(random_item());
        settle();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_item(make_item(ACT_PIXEL, 0, 0, 0, 1'b1));
        send_item(make_item(ACT_PIXEL, 127, 63, 0, 1'b1));
        send_item(make_item(ACT_PIXEL, 127, 0, 0, 1'b1));
        send_item(make_item(ACT_PIXEL, 0, 63, 0, 1'b1));
        send_item(make_item(ACT_PIXEL, 5, 9, 0, 1'b1));
        send_item(make_item(ACT_PIXEL, 5, 9, 255, 1'b0));
        send_item(make_item(ACT_PIXEL, 5, 10, 0, 1'b1));
        send_item(make_item(ACT_FLUSH, 0, 0, 128, 1'b0));
        send_item(make_item(ACT_FLUSH, 0, 63, 255, 1'b1));
        send_item(make_item(ACT_FLUSH, 120, 8, 255, 1'b0));
        send_item(make_item(ACT_FLUSH, 127, 56, 1, 1'b0));
        send_item(make_item(ACT_FLUSH, 3, 8, 0, 1'b0));
        send_item(make_item(ACT_FLUSH, 0, 8, 5, 1'b0));
        send_item(make_item(ACT_FLUSH, 2, 15, 9, 1'b0));
        send_item(make_item(ACT_UNUSED, 127, 63, 255, 1'b1));
        send_item(make_item(ACT_FILL, 0, 0, 0, 1'b1));
        send_item(make_item(ACT_PIXEL, 64, 31, 0, 1'b0));
        send_item(make_item(ACT_FLUSH, 60, 24, 10, 1'b0));
        send_item(make_item(ACT_FILL, 127, 63, 255, 1'b0));
        send_item(make_item(ACT_FLUSH, 0, 16, 8, 1'b0));
        run_random(15);

        configure(7'd32, 7'h7F, 7'd15);
        send_item(make_item(ACT_PIXEL, 10, 32, 0, 1'b1));
        send_item(make_item(ACT_PIXEL, 10, 31, 0, 1'b1));
        send_item(make_item(ACT_PIXEL, 10, 63, 0, 1'b1));
        send_item(make_item(ACT_FLUSH, 8, 24, 4, 1'b0));
        send_item(make_item(ACT_FLUSH, 8, 32, 4, 1'b0));
        send_item(make_item(ACT_FLUSH, 127, 63, 128, 1'b0));
        run_random(20);

        idle_pct = 0;
        configure(7'd64, 7'd0, 7'd0);
        run_random(20);
        idle_pct = 7;

        configure(7'd127, 7'd3, 7'd1);
        write_reg(REG_UNUSED, 7'h55);
        cfg_valid <= 1'b0;
        run_random(15);

        configure(7'($urandom_range(33, 63)), 7'($urandom_range(127)),
                  7'($urandom_range(127)));
        run_random(20);

        configure(7'd32, 7'd0, 7'd15);
        run_random(10);

        if (shadow.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pffe_pkg.sv
rtl/core/pffe_ram.sv
rtl/core/page_framebuffer_flush_engine_top.sv
rtl/core/pffe_checker.sv
bench/tb_page_framebuffer_flush_engine_top.sv
